### sv/ordered_array_table_unit_defines.svh
// Assertion macros shared by the ordered array table.
`ifndef ORDERED_ARRAY_TABLE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_TABLE_UNIT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define OAT_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define OAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/oat_pkg.sv
package oat_pkg;

  typedef enum logic [1:0] {
    REQ_READ,
    REQ_INSERT,
    REQ_REMOVE_AT,
    REQ_REMOVE_ALL
  } req_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_RANGE,
    STATUS_FULL,
    STATUS_NOT_FOUND
  } status_t;

  localparam logic signed [31:0] BAD_READ_VALUE = 32'sd9999999;

endpackage

### sv/oat_ram.sv
module oat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ordered_array_table_unit.sv
// Ordered array table: an ordered list of signed 32-bit entries held in one
// synchronous RAM, with a count of entries held.
// The request channel (req_valid, req_stall, req_type, position, item_value)
// takes one word at a time; the response channel (rsp_valid, rsp_stall,
// read_value, status, entry_count, removed_count) gives one word per request.
// A request is taken only while the unit is idle; req_stall is high while it
// works. An insert inside the list, a remove at a position and a remove of a
// value move or scan the entries through the single RAM write port, one entry
// per cycle. When the work ends the result waits in the finishing state until
// the output register is free, and is then loaded into it.
// The response sits in an output register, so the next request may be taken
// while it waits; if rsp_stall holds it, the next result waits in the unit and
// further requests stall. Synchronous reset empties the table at once and
// drops any pending response; the RAM contents need no clearing.
`include "ordered_array_table_unit_defines.svh"

module ordered_array_table_unit import oat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic [5:0]         position,
  input  logic signed [31:0] item_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [6:0]         entry_count,
  output logic [6:0]         removed_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UP,
    ST_UP_LAST,
    ST_DOWN,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      fill, fill_next;
  logic [CW-1:0]      wr_cnt, wr_cnt_next;
  logic [AW-1:0]      cur, cur_next;
  logic [AW-1:0]      pos_q, pos_next;
  logic signed [31:0] val_q, val_next;
  logic signed [31:0] res_rd, res_rd_next;
  status_t            res_st, res_st_next;
  logic [CW-1:0]      res_rm, res_rm_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          pos_ok;
  logic          full;
  logic [AW-1:0] last_addr;
  logic          keep;
  logic [CW-1:0] w_new;
  logic          rsp_load;

  oat_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pos_ok    = XW'(position) < XW'(fill);
  assign full      = fill == CW'(CAPACITY);
  assign last_addr = AW'(fill - CW'(1));
  assign keep      = $signed(ram_rdata) != val_q;
  assign w_new     = wr_cnt + CW'(keep);
  assign req_stall = state != ST_IDLE;
  assign rsp_load  = (state == ST_FIN) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    wr_cnt_next = wr_cnt;
    cur_next    = cur;
    pos_next    = pos_q;
    val_next    = val_q;
    res_rd_next = res_rd;
    res_st_next = res_st;
    res_rm_next = res_rm;
    ram_we      = 1'b0;
    ram_waddr   = cur;
    ram_wdata   = ram_rdata;
    ram_raddr   = cur;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          pos_next    = AW'(position);
          val_next    = item_value;
          res_rd_next = '0;
          res_st_next = STATUS_OK;
          res_rm_next = '0;
          case (req_kind_t'(req_type))
            REQ_READ: begin
              if (pos_ok) begin
                ram_raddr  = AW'(position);
                state_next = ST_READ;
              end else begin
                res_rd_next = BAD_READ_VALUE;
                res_st_next = STATUS_RANGE;
                state_next  = ST_FIN;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                res_st_next = STATUS_FULL;
                state_next  = ST_FIN;
              end else if (!pos_ok) begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(fill);
                ram_wdata  = item_value;
                fill_next  = fill + CW'(1);
                state_next = ST_FIN;
              end else begin
                ram_raddr  = last_addr;
                cur_next   = last_addr;
                state_next = ST_UP;
              end
            end
            REQ_REMOVE_AT: begin
              if (!pos_ok) begin
                res_st_next = STATUS_RANGE;
                state_next  = ST_FIN;
              end else begin
                res_rm_next = CW'(1);
                if (AW'(position) == last_addr) begin
                  fill_next  = fill - CW'(1);
                  state_next = ST_FIN;
                end else begin
                  ram_raddr  = AW'(position) + AW'(1);
                  cur_next   = AW'(position) + AW'(1);
                  state_next = ST_DOWN;
                end
              end
            end
            default: begin
              if (fill == '0) begin
                res_st_next = STATUS_NOT_FOUND;
                state_next  = ST_FIN;
              end else begin
                ram_raddr   = '0;
                cur_next    = '0;
                wr_cnt_next = '0;
                state_next  = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        res_rd_next = ram_rdata;
        state_next  = ST_FIN;
      end
      ST_UP: begin
        ram_we    = 1'b1;
        ram_waddr = cur + AW'(1);
        if (cur == pos_q) begin
          state_next = ST_UP_LAST;
        end else begin
          cur_next  = cur - AW'(1);
          ram_raddr = cur - AW'(1);
        end
      end
      ST_UP_LAST: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_q;
        ram_wdata  = val_q;
        fill_next  = fill + CW'(1);
        state_next = ST_FIN;
      end
      ST_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = cur - AW'(1);
        if (cur == last_addr) begin
          fill_next  = fill - CW'(1);
          state_next = ST_FIN;
        end else begin
          cur_next  = cur + AW'(1);
          ram_raddr = cur + AW'(1);
        end
      end
      ST_SCAN: begin
        ram_we      = keep;
        ram_waddr   = AW'(wr_cnt);
        wr_cnt_next = w_new;
        if (cur == last_addr) begin
          fill_next   = w_new;
          res_rm_next = fill - w_new;
          res_st_next = (w_new == fill) ? STATUS_NOT_FOUND : STATUS_OK;
          state_next  = ST_FIN;
        end else begin
          cur_next  = cur + AW'(1);
          ram_raddr = cur + AW'(1);
        end
      end
      ST_FIN: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    wr_cnt <= wr_cnt_next;
    cur    <= cur_next;
    pos_q  <= pos_next;
    val_q  <= val_next;
    res_rd <= res_rd_next;
    res_st <= res_st_next;
    res_rm <= res_rm_next;
    if (rsp_load) begin
      read_value    <= res_rd;
      status        <= res_st;
      entry_count   <= 7'(fill);
      removed_count <= 7'(res_rm);
    end
  end

  `OAT_ASSERT_NOW(a_fill_bound, fill <= CW'(CAPACITY), "Entry count exceeds capacity.")
  `OAT_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state != ST_IDLE, "Idle after accept.")
  `OAT_ASSERT_NEXT(a_rsp_load, rsp_load, rsp_valid && state == ST_IDLE, "Result not presented.")

endmodule

### tb/sv/tb_ordered_array_table_unit.sv
module tb_ordered_array_table_unit;
  import oat_pkg::*;

  localparam int CAPACITY = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 400;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [31:0] read_value;
    status_t status;
    logic [6:0] entry_count;
    logic [6:0] removed_count;
  } reply_t;

  class table_checker;
    logic signed [31:0] entries[CAPACITY];
    int fill;
    reply_t expected_replies[$];
    int errors;
    int replies_seen;
    int kind_seen[4];
    int full_refusals;
    int range_errors;
    int value_misses;
    int peak_fill;

    function new();
      fill = 0;
      errors = 0;
      replies_seen = 0;
      full_refusals = 0;
      range_errors = 0;
      value_misses = 0;
      peak_fill = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      foreach (entries[k]) entries[k] = '0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Applies one request to the table copy and queues the reply it must give.
    function void note_request(req_kind_t kind, logic [5:0] pos, logic signed [31:0] val);
      reply_t r;
      int i;
      int w;
      r.read_value = '0;
      r.status = STATUS_OK;
      r.removed_count = '0;
      kind_seen[kind]++;
      case (kind)
        REQ_READ: begin
          if (pos < fill) begin
            r.read_value = entries[pos];
          end else begin
            r.read_value = BAD_READ_VALUE;
            r.status = STATUS_RANGE;
          end
        end
        REQ_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = STATUS_FULL;
          end else begin
            if (pos >= fill) begin
              entries[fill] = val;
            end else begin
              for (i = fill; i > pos; i--) entries[i] = entries[i - 1];
              entries[pos] = val;
            end
            fill++;
          end
        end
        REQ_REMOVE_AT: begin
          if (pos >= fill) begin
            r.status = STATUS_RANGE;
          end else begin
            for (i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
            fill--;
            r.removed_count = 7'd1;
          end
        end
        default: begin
          w = 0;
          for (i = 0; i < fill; i++) begin
            if (entries[i] != val) begin
              entries[w] = entries[i];
              w++;
            end
          end
          r.removed_count = 7'(fill - w);
          fill = w;
          if (r.removed_count == 0) r.status = STATUS_NOT_FOUND;
        end
      endcase
      r.entry_count = 7'(fill);
      case (r.status)
        STATUS_FULL: full_refusals++;
        STATUS_RANGE: range_errors++;
        STATUS_NOT_FOUND: value_misses++;
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic signed [31:0] rd, logic [1:0] st, logic [6:0] cnt,
                              logic [6:0] rem);
      reply_t e;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected response word: value %0d status %0d count %0d removed %0d",
                   rd, st, cnt, rem);
        return;
      end
      e = expected_replies.pop_front();
      replies_seen++;
      if (rd !== e.read_value || st !== e.status || cnt !== e.entry_count ||
          rem !== e.removed_count) begin
        errors++;
        if (errors <= 10)
          $display("Response %0d mismatch: expected value %0d status %0d count %0d removed %0d, got value %0d status %0d count %0d removed %0d",
                   replies_seen, e.read_value, e.status, e.entry_count, e.removed_count,
                   rd, st, cnt, rem);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  logic [1:0] req_type;
  logic [5:0] position;
  logic signed [31:0] item_value;
  logic rsp_valid;
  logic rsp_stall;
  logic signed [31:0] read_value;
  logic [1:0] status;
  logic [6:0] entry_count;
  logic [6:0] removed_count;

  table_checker sb = new();
  bit steady = 1'b0;
  int accepted_reqs = 0;
  int idle_count = 0;

  ordered_array_table_unit #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .position(position),
    .item_value(item_value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .read_value(read_value),
    .status(status),
    .entry_count(entry_count),
    .removed_count(removed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        sb.note_request(req_kind_t'(req_type), position, item_value);
        accepted_reqs++;
      end
      if (rsp_valid && !rsp_stall) sb.check_reply(read_value, status, entry_count, removed_count);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= STALL_LIMIT) begin
        $display("No word moved for %0d cycles, giving up.", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // The response side stalls at random and, once, holds off long enough for
  // the unit to back up and stall its request side.
  initial begin
    bit held;
    held = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted_reqs >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_stall = !steady && ($urandom_range(99) < 38);
    end
  end

  task automatic offer_request(req_kind_t kind, logic [5:0] pos, logic signed [31:0] val);
    while (!steady && $urandom_range(99) < 38) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_type = kind;
    position = pos;
    item_value = val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 40) return $urandom();
    case ($urandom_range(7))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sd1;
      3: return 32'sd7;
      4: return 32'sh7fffffff;
      5: return 32'sh80000000;
      6: return 32'sd1000;
      default: return -32'sd1000;
    endcase
  endfunction

  function automatic logic [5:0] pick_position();
    int r;
    int c;
    r = $urandom_range(99);
    c = sb.fill;
    if (r < 55 && c > 0) return 6'($urandom_range(c - 1, 0));
    if (r < 75) return (c > 63) ? 6'd63 : 6'(c);
    return 6'($urandom_range(63, 0));
  endfunction

  // Modes: 0 mostly inserts, 1 an even mix, 2 mostly removals.
  task automatic random_request(int mode);
    int r;
    req_kind_t kind;
    r = $urandom_range(99);
    case (mode)
      0: kind = (r < 80) ? REQ_INSERT : (r < 90) ? REQ_READ :
                (r < 95) ? REQ_REMOVE_AT : REQ_REMOVE_ALL;
      1: kind = req_kind_t'($urandom_range(3));
      default: kind = (r < 45) ? REQ_REMOVE_AT : (r < 65) ? REQ_REMOVE_ALL : REQ_READ;
    endcase
    offer_request(kind, pick_position(), pick_value());
  endtask

  initial begin
    int k;
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_READ;
    position = '0;
    item_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer_request(REQ_READ, 6'd0, 32'sd0);
    offer_request(REQ_REMOVE_AT, 6'd0, 32'sd0);
    offer_request(REQ_REMOVE_ALL, 6'd0, 32'sd0);
    offer_request(REQ_INSERT, 6'd63, 32'sh7fffffff);
    offer_request(REQ_INSERT, 6'd0, 32'sh80000000);
    offer_request(REQ_INSERT, 6'd1, 32'sd0);
    offer_request(REQ_INSERT, 6'd1, -32'sd1);
    offer_request(REQ_INSERT, 6'd40, 32'sd5);
    offer_request(REQ_INSERT, 6'd2, 32'sd5);
    for (k = 0; k < 7; k++) offer_request(REQ_READ, 6'(k), 32'sd0);
    offer_request(REQ_READ, 6'd63, 32'sd0);
    offer_request(REQ_REMOVE_ALL, 6'd0, 32'sd5);
    offer_request(REQ_REMOVE_ALL, 6'd0, 32'sd123);
    offer_request(REQ_REMOVE_AT, 6'd0, 32'sd0);
    offer_request(REQ_REMOVE_AT, 6'd9, 32'sd0);
    offer_request(REQ_REMOVE_AT, 6'd2, 32'sd0);
    offer_request(REQ_READ, 6'd0, 32'sd0);

    for (k = 0; k < 4; k++) begin
      steady = (k == 1);
      repeat (100) random_request(0);
      steady = 1'b0;
      repeat (50) random_request(1);
      repeat (60) random_request(2);
    end
    req_valid = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d reads, %0d inserts, %0d position removes, %0d value removes; peak fill %0d of %0d.",
             accepted_reqs, sb.kind_seen[REQ_READ], sb.kind_seen[REQ_INSERT],
             sb.kind_seen[REQ_REMOVE_AT], sb.kind_seen[REQ_REMOVE_ALL], sb.peak_fill, CAPACITY);
    $display("Full-table refusals %0d, out-of-range requests %0d, value misses %0d, mismatches %0d.",
             sb.full_refusals, sb.range_errors, sb.value_misses, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/oat_pkg.sv
sv/oat_ram.sv
sv/ordered_array_table_unit.sv
tb/sv/tb_ordered_array_table_unit.sv
